[hw/rtl/prt_pkg.sv]
// Shared types, codes and sizing constants for the persistent request table.
package prt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int NODE_COUNT    = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NODE_IDX_W    = $clog2(NODE_COUNT);
  localparam int CNT_W         = $clog2(NODE_COUNT + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 42;
  localparam int NODE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Stream widths
  localparam int IN_BITS   = OP_W + ADDR_W + NODE_W + 1;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STATUS_W + 1 + 1 + NODE_W + 1 + COUNT_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOCK   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STARVING    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_MEMBER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MARKED      = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } prt_state_t;

  // One accepted request
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] line_addr;
    logic [NODE_W-1:0] node;
    logic              is_write;
  } prt_req_t;

  // The three node sets of one entry, as held in the set memory
  typedef struct packed {
    logic [NODE_COUNT-1:0] starving;
    logic [NODE_COUNT-1:0] marked;
    logic [NODE_COUNT-1:0] writes;
  } prt_sets_t;

  localparam int SETS_W = 3 * NODE_COUNT;

  // Outcome of the associative lookup
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } prt_lookup_t;

  // Tag array update
  typedef struct packed {
    logic             alloc;
    logic             release_entry;
    logic [IDX_W-1:0] idx;
  } prt_cam_wr_t;

  // One result beat
  typedef struct packed {
    logic [COUNT_W-1:0]  read_starving_count;
    logic [COUNT_W-1:0]  starving_count;
    logic                lowest_writes;
    logic [NODE_W-1:0]   lowest_node;
    logic                may_issue;
    logic                locked;
    logic [STATUS_W-1:0] status;
  } prt_result_t;

endpackage

[hw/rtl/persistent_request_table.sv]
// Top level: request sequencer around the tag array and the node set memory.
// Each request is captured, looked up in the tag array while its sets are read, then updated
// and written back with its result loaded into the output register; the next request is
// accepted only after that read-modify-write, which also waits while the result side stalls.
// A finished result may wait in the output register while the next request is accepted.
// Reset clears the valid bits and all control state; the tag and set stores need no clearing.
module persistent_request_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // op[1:0], line_addr[43:2], node[47:44], is_write[48], zero fill [55:49]
  input  logic [prt_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[2:0], locked[3], may_issue[4], lowest_node[8:5], lowest_writes[9],
  // starving_count[14:10], read_starving_count[19:15], zero fill [23:20]
  output logic [prt_pkg::OUT_DATA_W-1:0]    m_tdata
);

  prt_pkg::prt_state_t   state;
  prt_pkg::prt_state_t   state_next;
  prt_pkg::prt_req_t     req;
  prt_pkg::prt_lookup_t  lookup_comb;
  prt_pkg::prt_lookup_t  lookup;
  prt_pkg::prt_sets_t    sets_rd;
  prt_pkg::prt_sets_t    sets_wr;
  logic                  sets_we;
  logic [prt_pkg::IDX_W-1:0] entry_idx;
  prt_pkg::prt_cam_wr_t  cam_wr;
  prt_pkg::prt_result_t  result;
  logic                  in_beat;
  logic                  do_lookup;
  logic                  commit;
  logic [prt_pkg::SETS_W-1:0] ram_rd;

  assign in_beat = s_tvalid && s_tready;
  assign sets_rd = prt_pkg::prt_sets_t'(ram_rd);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      prt_pkg::S_IDLE: begin
        if (in_beat) begin
          state_next = prt_pkg::S_MATCH;
        end
      end
      prt_pkg::S_MATCH: begin
        state_next = prt_pkg::S_UPDATE;
      end
      prt_pkg::S_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          state_next = prt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = prt_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    do_lookup = 1'b0;
    commit    = 1'b0;
    case (state)
      prt_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      prt_pkg::S_MATCH: begin
        do_lookup = 1'b1;
      end
      prt_pkg::S_UPDATE: begin
        commit = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      req.op        <= s_tdata[1:0];
      req.line_addr <= s_tdata[43:2];
      req.node      <= s_tdata[47:44];
      req.is_write  <= s_tdata[48];
    end
  end

  // Hold the lookup outcome alongside the memory read
  always_ff @(posedge clk) begin
    if (do_lookup) begin
      lookup <= lookup_comb;
    end
  end

  prt_tag_cam u_cam (
    .clk       (clk),
    .rst       (rst),
    .line_addr (req.line_addr),
    .lookup    (lookup_comb),
    .wr_en     (commit),
    .wr        (cam_wr),
    .wr_tag    (req.line_addr)
  );

  prt_set_ram #(
    .ADDR_W (prt_pkg::IDX_W),
    .DATA_W (prt_pkg::SETS_W)
  ) u_sets (
    .clk     (clk),
    .wr_en   (commit && sets_we),
    .wr_addr (entry_idx),
    .wr_data (prt_pkg::SETS_W'(sets_wr)),
    .rd_en   (do_lookup),
    .rd_addr (lookup_comb.hit_idx),
    .rd_data (ram_rd)
  );

  prt_update u_update (
    .req       (req),
    .lookup    (lookup),
    .sets_rd   (sets_rd),
    .sets_we   (sets_we),
    .sets_wr   (sets_wr),
    .entry_idx (entry_idx),
    .cam_wr    (cam_wr),
    .result    (result)
  );

  // Output register: load on commit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= prt_pkg::OUT_DATA_W'(result);
    end
  end

endmodule

[hw/rtl/prt_set_ram.sv]
// Simple dual-port synchronous RAM with one write port and one registered read port.
module prt_set_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/prt_tag_cam.sv]
// Valid bits and line tags with parallel match and lowest-free-entry search.
module prt_tag_cam (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [prt_pkg::ADDR_W-1:0]   line_addr,
  output prt_pkg::prt_lookup_t         lookup,
  input  logic                         wr_en,
  input  prt_pkg::prt_cam_wr_t         wr,
  input  logic [prt_pkg::ADDR_W-1:0]   wr_tag
);

  logic [prt_pkg::TABLE_ENTRIES-1:0] valid;
  logic [prt_pkg::ADDR_W-1:0]        tag [prt_pkg::TABLE_ENTRIES];

  // Compare every entry; walk downwards so the lowest index wins
  always_comb begin
    lookup = '0;
    for (int i = prt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (tag[i] == line_addr)) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = prt_pkg::IDX_W'(i);
      end
      if (!valid[i]) begin
        lookup.free_ok  = 1'b1;
        lookup.free_idx = prt_pkg::IDX_W'(i);
      end
    end
  end

  // Valid bits: set on allocate, drop on release
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      if (wr.alloc) begin
        valid[wr.idx] <= 1'b1;
      end else if (wr.release_entry) begin
        valid[wr.idx] <= 1'b0;
      end
    end
  end

  // Tags: written only on allocate
  always_ff @(posedge clk) begin
    if (wr_en && wr.alloc) begin
      tag[wr.idx] <= wr_tag;
    end
  end

endmodule

[hw/rtl/prt_update.sv]
// Set update and result computation for one request against its entry.
module prt_update (
  input  prt_pkg::prt_req_t      req,
  input  prt_pkg::prt_lookup_t   lookup,
  input  prt_pkg::prt_sets_t     sets_rd,
  output logic                   sets_we,
  output prt_pkg::prt_sets_t     sets_wr,
  output logic [prt_pkg::IDX_W-1:0] entry_idx,
  output prt_pkg::prt_cam_wr_t   cam_wr,
  output prt_pkg::prt_result_t   result
);

  logic                           node_ok;
  logic [prt_pkg::NODE_COUNT-1:0] node_bit;
  logic                           present;
  logic [prt_pkg::STATUS_W-1:0]   status;
  prt_pkg::prt_sets_t             cur;
  prt_pkg::prt_sets_t             nxt;
  logic [prt_pkg::NODE_COUNT-1:0] wr_live;
  logic [prt_pkg::NODE_COUNT-1:0] rd_live;
  logic [prt_pkg::NODE_IDX_W-1:0] low_idx;
  logic                           low_wr;
  logic [prt_pkg::CNT_W-1:0]      s_cnt;
  logic [prt_pkg::CNT_W-1:0]      r_cnt;

  // Decode the node into a one-hot bit, empty when out of range
  always_comb begin
    node_ok  = int'(req.node) < prt_pkg::NODE_COUNT;
    node_bit = '0;
    for (int i = 0; i < prt_pkg::NODE_COUNT; i++) begin
      node_bit[i] = node_ok && (int'(req.node) == i);
    end
  end

  // Apply the operation to the entry's sets
  always_comb begin
    cur       = lookup.hit ? sets_rd : '0;
    nxt       = cur;
    status    = prt_pkg::ST_OK;
    present   = lookup.hit;
    entry_idx = lookup.hit_idx;
    sets_we   = 1'b0;
    cam_wr    = '0;
    case (req.op)
      prt_pkg::OP_LOCK: begin
        if (!node_ok) begin
          status = prt_pkg::ST_NOT_MEMBER;
        end else if (lookup.hit) begin
          if ((cur.starving & node_bit) != '0) begin
            status = prt_pkg::ST_STARVING;
          end else begin
            nxt.starving = cur.starving | node_bit;
            if (req.is_write) begin
              nxt.writes = cur.writes | node_bit;
            end
            sets_we = 1'b1;
          end
        end else if (lookup.free_ok) begin
          nxt.starving = node_bit;
          nxt.marked   = '0;
          nxt.writes   = req.is_write ? node_bit : '0;
          sets_we      = 1'b1;
          present      = 1'b1;
          entry_idx    = lookup.free_idx;
          cam_wr.alloc = 1'b1;
        end else begin
          status = prt_pkg::ST_FULL;
        end
      end
      prt_pkg::OP_UNLOCK: begin
        if (!node_ok || !lookup.hit || ((cur.starving & node_bit) == '0)) begin
          status = prt_pkg::ST_NOT_MEMBER;
        end else begin
          nxt.starving = cur.starving & ~node_bit;
          nxt.marked   = cur.marked & ~node_bit;
          nxt.writes   = cur.writes & ~node_bit;
          if (nxt.starving == '0) begin
            // Last starving node gone: free the entry
            present              = 1'b0;
            cam_wr.release_entry = 1'b1;
          end else begin
            sets_we = 1'b1;
          end
        end
      end
      prt_pkg::OP_MARK: begin
        if (lookup.hit) begin
          if (cur.marked != '0) begin
            status = prt_pkg::ST_MARKED;
          end else begin
            nxt.marked = cur.starving;
            sets_we    = 1'b1;
          end
        end
      end
      prt_pkg::OP_QUERY: begin
        status = prt_pkg::ST_OK;
      end
      default: begin
        status = prt_pkg::ST_OK;
      end
    endcase
    cam_wr.idx = entry_idx;
    sets_wr    = nxt;
  end

  // Lowest starving node and the set counts
  always_comb begin
    wr_live = nxt.writes & nxt.starving;
    rd_live = nxt.starving & ~wr_live;
    low_idx = '0;
    low_wr  = 1'b0;
    s_cnt   = '0;
    r_cnt   = '0;
    for (int i = prt_pkg::NODE_COUNT - 1; i >= 0; i--) begin
      if (nxt.starving[i]) begin
        low_idx = prt_pkg::NODE_IDX_W'(i);
        low_wr  = wr_live[i];
      end
    end
    for (int i = 0; i < prt_pkg::NODE_COUNT; i++) begin
      s_cnt = s_cnt + prt_pkg::CNT_W'(nxt.starving[i]);
      r_cnt = r_cnt + prt_pkg::CNT_W'(rd_live[i]);
    end
  end

  // Form the result beat for the line as it stands afterwards
  always_comb begin
    result        = '0;
    result.status = status;
    result.may_issue = 1'b1;
    if (present) begin
      result.locked    = 1'b1;
      result.may_issue = ((nxt.starving & node_bit) == '0) && (nxt.marked == '0);
      result.lowest_node = prt_pkg::NODE_W'(
          {{prt_pkg::NODE_W{1'b0}}, low_idx} & {prt_pkg::NODE_W{1'b1}});
      result.lowest_writes       = low_wr;
      result.starving_count      = prt_pkg::COUNT_W'(
          {{prt_pkg::COUNT_W{1'b0}}, s_cnt} & {prt_pkg::COUNT_W{1'b1}});
      result.read_starving_count = prt_pkg::COUNT_W'(
          {{prt_pkg::COUNT_W{1'b0}}, r_cnt} & {prt_pkg::COUNT_W{1'b1}});
    end
  end

endmodule
